>>> sv/biquad_iir_q15_filter_unit_defines.svh
// Assertion macros shared by the biquad filter RTL.
// Depends on a clock named clk and an active-low reset named rst_n in scope.
`ifndef BIQUAD_IIR_Q15_FILTER_UNIT_DEFINES_SVH
`define BIQUAD_IIR_Q15_FILTER_UNIT_DEFINES_SVH

// Concurrent check sampled on clk and disabled while reset is asserted.
`define BIQ_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Concurrent check that also holds during reset.
`define BIQ_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

>>> sv/biq_pkg.sv
// Package for the biquad filter: widths, register indexes, reset coefficients.
// Used by every module of the filter; depends on nothing.
package biq_pkg;

  localparam int SAMPLE_W  = 16;
  localparam int PROD_W    = 32;
  localparam int TERM_W    = 17;
  localparam int ACC_W     = 20;
  localparam int NUM_COEFS = 5;
  localparam int CFG_IDX_W = 3;

  localparam logic [CFG_IDX_W-1:0] CFG_B0 = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_B1 = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_B2 = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_A1 = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_A2 = 3'd4;

  localparam logic signed [SAMPLE_W-1:0] RST_B0 = 16'sh10C8;
  localparam logic signed [SAMPLE_W-1:0] RST_B1 = 16'sh2190;
  localparam logic signed [SAMPLE_W-1:0] RST_B2 = 16'sh10C8;
  localparam logic signed [SAMPLE_W-1:0] RST_A1 = 16'sh5FB7;
  localparam logic signed [SAMPLE_W-1:0] RST_A2 = 16'shDD28;

  localparam logic signed [PROD_W-1:0] ROUND_ADD = 32'sd16384;
  localparam logic signed [ACC_W-1:0]  CLIP_MAX  = 20'sd32767;
  localparam logic signed [ACC_W-1:0]  CLIP_MIN  = -20'sd32767;

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic signed [TERM_W-1:0]   term_t;
  typedef logic signed [ACC_W-1:0]    acc_t;

  typedef struct packed {
    sample_t b0;
    sample_t b1;
    sample_t b2;
    sample_t a1;
    sample_t a2;
  } coef_set_t;

  typedef struct packed {
    sample_t in_hist1;
    sample_t in_hist2;
    sample_t out_hist1;
    sample_t out_hist2;
  } hist_t;

  function automatic acc_t sext_term(input term_t t);
    return {{(ACC_W-TERM_W){t[TERM_W-1]}}, t};
  endfunction

endpackage

>>> sv/biq_tap.sv
// One filter tap: Q15 product with round-half-up and a sticky LSB.
// Depends on biq_pkg.
module biq_tap (
  input  biq_pkg::sample_t coef,
  input  biq_pkg::sample_t sample,
  output biq_pkg::term_t   term
);
  import biq_pkg::*;

  logic signed [PROD_W-1:0] prod;
  logic signed [PROD_W-1:0] rnd;
  logic                     sticky;

  assign prod   = coef * sample;
  assign rnd    = prod + ROUND_ADD;
  assign sticky = |rnd[14:0];
  assign term   = {rnd[PROD_W-1:16], rnd[15] | sticky};

endmodule

>>> sv/biq_datapath.sv
// Five taps, their sum and the symmetric clip of one filter output sample.
// Depends on biq_pkg and biq_tap.
module biq_datapath (
  input  biq_pkg::coef_set_t coefs,
  input  biq_pkg::hist_t     hist,
  input  biq_pkg::sample_t   x,
  output biq_pkg::sample_t   y
);
  import biq_pkg::*;

  term_t t_b0, t_b1, t_b2, t_a1, t_a2;
  acc_t  acc;

  biq_tap u_tap_b0 (.coef(coefs.b0), .sample(x),              .term(t_b0));
  biq_tap u_tap_b1 (.coef(coefs.b1), .sample(hist.in_hist1),  .term(t_b1));
  biq_tap u_tap_b2 (.coef(coefs.b2), .sample(hist.in_hist2),  .term(t_b2));
  biq_tap u_tap_a1 (.coef(coefs.a1), .sample(hist.out_hist1), .term(t_a1));
  biq_tap u_tap_a2 (.coef(coefs.a2), .sample(hist.out_hist2), .term(t_a2));

  assign acc = sext_term(t_b0) + sext_term(t_b1) + sext_term(t_b2)
             + sext_term(t_a1) + sext_term(t_a2);

  always_comb begin
    priority if (acc > CLIP_MAX) begin
      y = CLIP_MAX[SAMPLE_W-1:0];
    end else if (acc < CLIP_MIN) begin
      y = CLIP_MIN[SAMPLE_W-1:0];
    end else begin
      y = acc[SAMPLE_W-1:0];
    end
  end

endmodule

>>> sv/biquad_iir_q15_filter_unit.sv
// Top level of the direct-form-I Q15 biquad filter: handshakes, coefficient
// registers, sample history and result register. Depends on biq_pkg, biq_datapath.
//
//  channel | direction | beat carries
//  in_     | slave     | in_tdata[15:0]  = sample_in
//  out_    | master    | out_tdata[15:0] = sample_out
//  cfg_    | slave     | cfg_index[2:0], cfg_data[15:0] = coefficient
//
// A sample passes through the input register and then the result register.
// One sample is accepted per cycle unless the output stalls; the feedback path
// through the five multipliers and the adder tree is combinational.
// Synchronous reset restores the default coefficients and clears the history.
// A stalled output holds the result and backs up only the input register.
module biquad_iir_q15_filter_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // [15:0] sample_in
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // [15:0] sample_out
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [biq_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [15:0] cfg_data
);
  import biq_pkg::*;
  `include "biquad_iir_q15_filter_unit_defines.svh"

  coef_set_t coefs_r;
  hist_t     hist_r;
  sample_t   x_r;
  logic      x_valid_r;
  sample_t   y_r;
  logic      y_valid_r;
  sample_t   y_nxt;
  logic      advance;

  assign advance    = x_valid_r && (!y_valid_r || out_tready);
  assign in_tready  = !x_valid_r || advance;
  assign out_tvalid = y_valid_r;
  assign out_tdata  = y_r;
  assign cfg_ready  = 1'b1;

  biq_datapath u_datapath (
    .coefs(coefs_r),
    .hist (hist_r),
    .x    (x_r),
    .y    (y_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coefs_r   <= '{b0: RST_B0, b1: RST_B1, b2: RST_B2, a1: RST_A1, a2: RST_A2};
      hist_r    <= '0;
      x_valid_r <= 1'b0;
      y_valid_r <= 1'b0;
    end else begin
      if (cfg_valid) begin
        unique case (cfg_index)
          CFG_B0:  coefs_r.b0 <= cfg_data;
          CFG_B1:  coefs_r.b1 <= cfg_data;
          CFG_B2:  coefs_r.b2 <= cfg_data;
          CFG_A1:  coefs_r.a1 <= cfg_data;
          CFG_A2:  coefs_r.a2 <= cfg_data;
          default: ;
        endcase
      end
      if (in_tready) begin
        x_valid_r <= in_tvalid;
      end
      if (advance) begin
        y_valid_r        <= 1'b1;
        hist_r.in_hist1  <= x_r;
        hist_r.in_hist2  <= hist_r.in_hist1;
        hist_r.out_hist1 <= y_nxt;
        hist_r.out_hist2 <= hist_r.out_hist1;
      end else if (out_tready) begin
        y_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      x_r <= in_tdata;
    end
    if (advance) begin
      y_r <= y_nxt;
    end
  end

  `BIQ_ASSERT(a_no_neg_full_scale, out_tvalid |-> (out_tdata != 16'h8000), "output reached -32768")
  `BIQ_ASSERT(a_ready_when_empty, (!y_valid_r) |-> in_tready, "input stalled with empty output")
  `BIQ_ASSERT(a_advance_fills_out, advance |=> out_tvalid, "computed sample not presented")
  `BIQ_ASSERT(a_hist_tracks_out, advance |=> (hist_r.out_hist1 == y_r), "history differs from result")
  `BIQ_ASSERT(a_cfg_b0_write, (cfg_valid && cfg_index == CFG_B0) |=> (coefs_r.b0 == $past(cfg_data)), "b0 write lost")

endmodule

>>> bench/biquad_iir_q15_filter_unit_test.sv
// Testbench for biquad_iir_q15_filter_unit: a table of directed samples and coefficient
// writes, then random phases with gaps, stalls and back-pressure. Outputs are scored
// against a built-in Q15 predictor or table result. Depends on biq_pkg and filter RTL.
module biquad_iir_q15_filter_unit_test;
  import biq_pkg::*;

  localparam int PHASES = 6;
  localparam int PHASE_SAMPLES = 300;
  localparam int LONG_HOLD = 64;
  localparam int DRAIN_CYCLES = 8;
  localparam int SHIFT_Q15 = 15;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 3'd7;

  typedef enum logic {ROW_SAMPLE, ROW_WRITE} row_kind_t;
  typedef enum int {COEF_RESET, COEF_FULL, COEF_EXTREME, COEF_MILD} coef_style_t;

  typedef struct {
    row_kind_t kind;
    logic [CFG_IDX_W-1:0] idx;
    sample_t value;
    bit known;
    sample_t result;
  } stim_row_t;

  localparam sample_t RESET_COEFS [NUM_COEFS] = '{RST_B0, RST_B1, RST_B2, RST_A1, RST_A2};
  localparam sample_t EXTREME_VALUES [5] = '{16'sh8000, 16'sh7FFF, 16'sh0000, 16'shFFFF,
                                             16'sh0001};
  localparam int DIRECTED_ROWS = 30;

  stim_row_t directed_rows [DIRECTED_ROWS] = '{
    '{ROW_SAMPLE, CFG_B0, 16'sh0000, 1'b1, 16'sh0005},
    '{ROW_SAMPLE, CFG_B0, 16'sh7FFF, 1'b0, 16'sh0000},
    '{ROW_SAMPLE, CFG_B0, 16'sh8000, 1'b0, 16'sh0000},
    '{ROW_SAMPLE, CFG_B0, 16'sh0001, 1'b0, 16'sh0000},
    '{ROW_SAMPLE, CFG_B0, 16'shFFFF, 1'b0, 16'sh0000},
    '{ROW_SAMPLE, CFG_B0, 16'sh5555, 1'b0, 16'sh0000},
    '{ROW_SAMPLE, CFG_B0, 16'shAAAA, 1'b0, 16'sh0000},
    '{ROW_WRITE,  CFG_B0, 16'sh8000, 1'b0, 16'sh0000},
    '{ROW_WRITE,  CFG_B1, 16'sh8000, 1'b0, 16'sh0000},
    '{ROW_WRITE,  CFG_B2, 16'sh8000, 1'b0, 16'sh0000},
    '{ROW_WRITE,  CFG_A1, 16'sh8000, 1'b0, 16'sh0000},
    '{ROW_WRITE,  CFG_A2, 16'sh8000, 1'b0, 16'sh0000},
    '{ROW_WRITE,  CFG_SPARE_LO, 16'sh1234, 1'b0, 16'sh0000},
    '{ROW_WRITE,  CFG_SPARE_HI, 16'sh7FFF, 1'b0, 16'sh0000},
    '{ROW_SAMPLE, CFG_B0, 16'sh8000, 1'b0, 16'sh0000},
    '{ROW_SAMPLE, CFG_B0, 16'sh8000, 1'b0, 16'sh0000},
    '{ROW_SAMPLE, CFG_B0, 16'sh8000, 1'b0, 16'sh0000},
    '{ROW_WRITE,  CFG_B0, 16'sh7FFF, 1'b0, 16'sh0000},
    '{ROW_WRITE,  CFG_B1, 16'sh7FFF, 1'b0, 16'sh0000},
    '{ROW_WRITE,  CFG_B2, 16'sh7FFF, 1'b0, 16'sh0000},
    '{ROW_WRITE,  CFG_A1, 16'sh0000, 1'b0, 16'sh0000},
    '{ROW_WRITE,  CFG_A2, 16'sh0000, 1'b0, 16'sh0000},
    '{ROW_SAMPLE, CFG_B0, 16'sh8000, 1'b1, 16'sh8001},
    '{ROW_SAMPLE, CFG_B0, 16'sh8000, 1'b1, 16'sh8001},
    '{ROW_SAMPLE, CFG_B0, 16'sh8000, 1'b1, 16'sh8001},
    '{ROW_WRITE,  CFG_B0, 16'sh8000, 1'b0, 16'sh0000},
    '{ROW_WRITE,  CFG_B1, 16'sh8000, 1'b0, 16'sh0000},
    '{ROW_WRITE,  CFG_B2, 16'sh8000, 1'b0, 16'sh0000},
    '{ROW_SAMPLE, CFG_B0, 16'sh8000, 1'b1, 16'sh7FFF},
    '{ROW_SAMPLE, CFG_B0, 16'sh8000, 1'b1, 16'sh7FFF}
  };

  logic clk = 1'b0;
  logic rst_n;
  logic in_tvalid;
  logic in_tready;
  logic [15:0] in_tdata;   // [15:0] sample_in
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [15:0] out_tdata;  // [15:0] sample_out
  logic cfg_valid;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [15:0] cfg_data;

  sample_t coef_set [NUM_COEFS];
  sample_t x_d1, x_d2, y_d1, y_d2;
  sample_t expected_out [$];
  int error_count = 0;
  int gap_pct = 0;
  int stall_pct = 0;
  logic hold_armed = 1'b0;
  int hold_count = 0;

  biquad_iir_q15_filter_unit dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_tvalid(in_tvalid),
    .in_tready(in_tready),
    .in_tdata(in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata(out_tdata),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #2 clk = ~clk;

  function automatic longint scaled_term(input sample_t c, input sample_t s);
    longint p;
    p = longint'(c) * longint'(s) + longint'(ROUND_ADD);
    if (p[14:0] != 15'd0) p[15] = 1'b1;
    return p >>> SHIFT_Q15;
  endfunction

  function automatic sample_t filter_next(input sample_t x);
    longint acc;
    sample_t y;
    acc = scaled_term(coef_set[CFG_B0], x) + scaled_term(coef_set[CFG_B1], x_d1)
        + scaled_term(coef_set[CFG_B2], x_d2) + scaled_term(coef_set[CFG_A1], y_d1)
        + scaled_term(coef_set[CFG_A2], y_d2);
    if (acc > longint'(CLIP_MAX)) acc = longint'(CLIP_MAX);
    if (acc < longint'(CLIP_MIN)) acc = longint'(CLIP_MIN);
    y = acc[15:0];
    x_d2 = x_d1;
    x_d1 = x;
    y_d2 = y_d1;
    y_d1 = y;
    return y;
  endfunction

  task automatic report_mismatch(input string what);
    $display("ERROR at %0t: %s", $time, what);
    error_count++;
  endtask

  task automatic wait_drained();
    in_tvalid <= 1'b0;
    while (expected_out.size() != 0) @(posedge clk);
  endtask

  task automatic write_coef(input logic [CFG_IDX_W-1:0] idx, input sample_t val);
    wait_drained();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    if (idx < NUM_COEFS) coef_set[idx] = val;
  endtask

  task automatic send_sample(input sample_t x, input bit known, input sample_t typed);
    sample_t y;
    cfg_valid <= 1'b0;
    while ($urandom_range(99) < gap_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= x;
    do @(posedge clk); while (!in_tready);
    y = filter_next(x);
    expected_out.push_back(known ? typed : y);
  endtask

  // Receiver: random stalls, plus one long hold-off once armed.
  always @(posedge clk) begin
    if (hold_armed && hold_count < LONG_HOLD) begin
      out_tready <= 1'b0;
      hold_count <= hold_count + 1;
    end else begin
      out_tready <= ($urandom_range(99) >= stall_pct);
    end
  end

  always @(posedge clk) begin
    sample_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_out.size() == 0) begin
        report_mismatch($sformatf("sample_out %0d with nothing expected", $signed(out_tdata)));
      end else begin
        want = expected_out.pop_front();
        if (out_tdata !== want)
          report_mismatch($sformatf("sample_out %0d, expected %0d", $signed(out_tdata), want));
      end
    end
  end

  initial begin
    coef_style_t style;
    sample_t x;
    sample_t c;
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    for (int i = 0; i < NUM_COEFS; i++) coef_set[i] = RESET_COEFS[i];
    x_d1 = '0;
    x_d2 = '0;
    y_d1 = '0;
    y_d2 = '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_rows[r]) begin
      if (directed_rows[r].kind == ROW_WRITE) begin
        write_coef(directed_rows[r].idx, directed_rows[r].value);
      end else begin
        send_sample(directed_rows[r].value, directed_rows[r].known, directed_rows[r].result);
      end
    end

    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0: begin style = COEF_RESET;   gap_pct = 0;  stall_pct = 0;  end
        1: begin style = COEF_FULL;    gap_pct = 77; stall_pct = 0;  end
        2: begin style = COEF_EXTREME; gap_pct = 0;  stall_pct = 77; end
        3: begin style = COEF_MILD;    gap_pct = 33; stall_pct = 33; end
        4: begin style = COEF_FULL;    gap_pct = 0;  stall_pct = 0;  end
        default: begin style = COEF_MILD; gap_pct = 77; stall_pct = 0; end
      endcase
      for (int i = 0; i < NUM_COEFS; i++) begin
        case (style)
          COEF_RESET: c = RESET_COEFS[i];
          COEF_FULL: c = sample_t'($urandom);
          COEF_EXTREME: c = EXTREME_VALUES[$urandom_range(4)];
          default: c = sample_t'(int'($urandom_range(16383)) - 8192);
        endcase
        write_coef(CFG_IDX_W'(i), c);
      end
      for (int n = 0; n < PHASE_SAMPLES; n++) begin
        if (p == 4 && n == 100) hold_armed <= 1'b1;
        if (p == 5 && n == 150) wait_drained();
        case ($urandom_range(9))
          0: x = EXTREME_VALUES[$urandom_range(4)];
          1, 2, 3: x = sample_t'(int'($urandom_range(511)) - 256);
          default: x = sample_t'($urandom);
        endcase
        send_sample(x, 1'b0, '0);
      end
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin
    #4000000;
    $display("Verification failed");
    $finish;
  end

endmodule
